### sv/assert_macros.svh
// Assertion macros shared by the queue RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on the rising clock edge, outside reset.
`define MLPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that a condition implies a consequence in the same cycle.
`define MLPQ_ASSERT_IMP(lbl, ante, cons, msg) \
  `MLPQ_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

### sv/mlpq_pkg.sv
// Types and constants shared by the multi-level priority queue.
package mlpq_pkg;

  localparam int MAX_LEVELS = 8;
  localparam int ITEM_WIDTH = 32;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_PRIO = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  typedef struct packed {
    logic take;
    logic finish_read;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_valid;
    logic need_read;
  } dp_status_t;

endpackage

### sv/mlpq_ctrl.sv
// Controller of the priority queue: request acceptance and memory read sequencing.
module mlpq_ctrl import mlpq_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_tvalid_i,
  input  logic       m_tready_i,
  input  dp_status_t status_i,
  output logic       s_tready_o,
  output ctrl_cmd_t  cmd_o
);

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    s_tready_o = 1'b0;
    cmd_o = '0;
    unique case (state_q)
      S_IDLE: begin
        s_tready_o = !status_i.out_valid || m_tready_i;
        cmd_o.take = s_tvalid_i && s_tready_o;
        if (cmd_o.take && status_i.need_read) begin
          state_d = S_READ;
        end
      end
      S_READ: begin
        cmd_o.finish_read = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### sv/mlpq_dp.sv
// Datapath of the priority queue: level store, per-level pointers, result register.
module mlpq_dp import mlpq_pkg::*; #(
  parameter int LEVEL_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_wdata_i,
  input  logic        command_i,
  input  logic [31:0] item_value_i,
  input  logic [2:0]  priority_req_i,
  input  logic        m_tready_i,
  input  ctrl_cmd_t   cmd_i,
  output dp_status_t  status_o,
  output logic [31:0] removed_value_o,
  output status_e     status_code_o,
  output logic        queue_empty_o,
  output logic        queue_full_o,
  output logic [3:0]  levels_o
);

  localparam int LVL_W = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
  localparam int PTR_W = $clog2(LEVEL_DEPTH);
  localparam int CNT_W = $clog2(LEVEL_DEPTH + 1);
  localparam int ADDR_W = LVL_W + PTR_W;
  localparam int MEM_DEPTH = 1 << ADDR_W;

  logic [ITEM_WIDTH-1:0] mem [MEM_DEPTH];
  logic [ITEM_WIDTH-1:0] rdata_q;

  logic [3:0]       levels_q;
  logic [PTR_W-1:0] head_q [MAX_LEVELS];
  logic [PTR_W-1:0] head_d [MAX_LEVELS];
  logic [PTR_W-1:0] tail_q [MAX_LEVELS];
  logic [PTR_W-1:0] tail_d [MAX_LEVELS];
  logic [CNT_W-1:0] cnt_q  [MAX_LEVELS];
  logic [CNT_W-1:0] cnt_d  [MAX_LEVELS];

  logic [MAX_LEVELS-1:0] in_use;
  logic                  hit;
  logic [LVL_W-1:0]      sel;
  logic                  prio_ok;
  logic [LVL_W-1:0]      p_idx;
  logic                  lvl_full;
  logic                  do_write;
  logic                  do_read;
  logic                  load_now;
  status_e               code_d;
  logic                  empty_d;
  logic                  full_d;

  logic                  out_valid_q;
  logic [31:0]           value_q;
  status_e               code_q;
  logic                  empty_q;
  logic                  full_q;

  function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] s);
    return (s == PTR_W'(LEVEL_DEPTH - 1)) ? '0 : s + PTR_W'(1);
  endfunction

  always_comb begin
    hit = 1'b0;
    sel = '0;
    for (int i = 0; i < MAX_LEVELS; i++) begin
      in_use[i] = 32'(levels_q) > i;
      if (in_use[i] && cnt_q[i] != '0) begin
        hit = 1'b1;
        sel = LVL_W'(i);
      end
    end
  end

  assign prio_ok  = (32'(priority_req_i) < MAX_LEVELS) && ({1'b0, priority_req_i} < levels_q);
  assign p_idx    = LVL_W'(priority_req_i);
  assign lvl_full = cnt_q[p_idx] == CNT_W'(LEVEL_DEPTH);
  assign do_write = cmd_i.take && command_i == CMD_INSERT && prio_ok && !lvl_full;
  assign do_read  = cmd_i.take && command_i == CMD_REMOVE && hit;
  assign load_now = cmd_i.take && !do_read;

  assign status_o.out_valid = out_valid_q;
  assign status_o.need_read = command_i == CMD_REMOVE && hit;

  always_comb begin
    for (int i = 0; i < MAX_LEVELS; i++) begin
      head_d[i] = head_q[i];
      tail_d[i] = tail_q[i];
      cnt_d[i]  = cnt_q[i];
    end
    if (do_write) begin
      tail_d[p_idx] = next_slot(tail_q[p_idx]);
      cnt_d[p_idx]  = cnt_q[p_idx] + CNT_W'(1);
    end
    if (do_read) begin
      head_d[sel] = next_slot(head_q[sel]);
      cnt_d[sel]  = cnt_q[sel] - CNT_W'(1);
    end
  end

  always_comb begin
    empty_d = 1'b1;
    full_d  = 1'b1;
    for (int i = 0; i < MAX_LEVELS; i++) begin
      if (in_use[i] && cnt_d[i] != '0) begin
        empty_d = 1'b0;
      end
      if (in_use[i] && cnt_d[i] != CNT_W'(LEVEL_DEPTH)) begin
        full_d = 1'b0;
      end
    end
  end

  always_comb begin
    code_d = ST_OK;
    if (command_i == CMD_REMOVE) begin
      code_d = ST_EMPTY;
    end else if (!prio_ok) begin
      code_d = ST_BAD_PRIO;
    end else if (lvl_full) begin
      code_d = ST_FULL;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_write) begin
      mem[{p_idx, tail_q[p_idx]}] <= ITEM_WIDTH'(item_value_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_read) begin
      rdata_q <= mem[{sel, head_q[sel]}];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      levels_q <= 4'd8;
      for (int i = 0; i < MAX_LEVELS; i++) begin
        head_q[i] <= '0;
        tail_q[i] <= '0;
        cnt_q[i]  <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        levels_q <= cfg_wdata_i;
      end
      for (int i = 0; i < MAX_LEVELS; i++) begin
        head_q[i] <= head_d[i];
        tail_q[i] <= tail_d[i];
        cnt_q[i]  <= cnt_d[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_now || cmd_i.finish_read) begin
      out_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_now) begin
      value_q <= '0;
      code_q  <= code_d;
      empty_q <= empty_d;
      full_q  <= full_d;
    end else if (cmd_i.finish_read) begin
      value_q <= 32'(rdata_q);
      code_q  <= ST_OK;
      empty_q <= empty_d;
      full_q  <= full_d;
    end
  end

  assign removed_value_o = value_q;
  assign status_code_o   = code_q;
  assign queue_empty_o   = empty_q;
  assign queue_full_o    = full_q;
  assign levels_o        = levels_q;

endmodule

### sv/multi_level_priority_queue.sv
// Strict-priority queue with one FIFO per level; top level of the block.
// An insert or an unsuccessful remove shows its result in the cycle after acceptance;
// a successful remove passes the level-store read register, then the result register.
// Throughput: one insert per cycle unless results stall; a successful remove blocks new requests during its read.
// The result register lets a new request enter in the cycle its predecessor's result is taken.
// Reset clears all levels to empty and sets the levels-in-use register to eight.
`include "assert_macros.svh"
module multi_level_priority_queue import mlpq_pkg::*; #(
  parameter int LEVEL_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [31:0] item_value, [34:32] priority_req, [39:35] zero.
  input  logic [39:0] s_axis_tdata_i,
  // [0] command.
  input  logic        s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [31:0] removed_value, [33:32] status, [34] queue_empty, [35] queue_full, [39:36] zero.
  output logic [39:0] m_axis_tdata_o
);

  ctrl_cmd_t   cmd;
  dp_status_t  dp_status;
  logic [31:0] removed_value;
  status_e     status_code;
  logic        queue_empty;
  logic        queue_full;
  logic [3:0]  levels;

  mlpq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .m_tready_i (m_axis_tready_i),
    .status_i   (dp_status),
    .s_tready_o (s_axis_tready_o),
    .cmd_o      (cmd)
  );

  mlpq_dp #(
    .LEVEL_DEPTH (LEVEL_DEPTH)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .command_i       (s_axis_tuser_i),
    .item_value_i    (s_axis_tdata_i[31:0]),
    .priority_req_i  (s_axis_tdata_i[34:32]),
    .m_tready_i      (m_axis_tready_i),
    .cmd_i           (cmd),
    .status_o        (dp_status),
    .removed_value_o (removed_value),
    .status_code_o   (status_code),
    .queue_empty_o   (queue_empty),
    .queue_full_o    (queue_full),
    .levels_o        (levels)
  );

  assign m_axis_tvalid_o = dp_status.out_valid;
  assign m_axis_tdata_o  = {4'd0, queue_full, queue_empty, status_code, removed_value};

  `MLPQ_ASSERT_IMP(a_fail_no_value, m_axis_tvalid_o && status_code != ST_OK, removed_value == 32'd0, "failed request returned a value")
  `MLPQ_ASSERT_IMP(a_empty_full_excl, m_axis_tvalid_o && levels != 4'd0, !(queue_empty && queue_full), "queue reported empty and full")
  `MLPQ_ASSERT(a_insert_result, s_axis_tvalid_i && s_axis_tready_o && s_axis_tuser_i == CMD_INSERT |=> m_axis_tvalid_o, "insert gave no result")
  `MLPQ_ASSERT(a_read_result, cmd.finish_read |=> m_axis_tvalid_o && status_code == ST_OK, "remove gave no result")

endmodule

### dv/testbench.sv
// Self-checking testbench for the multi-level strict-priority queue.
`timescale 1ns / 1ps

module testbench import mlpq_pkg::*;;

  localparam int NUM_LEVELS = 8;
  localparam int SLOTS      = 16;

  typedef struct {
    logic [31:0] value;
    status_e     status;
    logic        empty;
    logic        full;
  } pq_reply_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [3:0]  cfg_wdata_i;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [39:0] s_axis_tdata_i;
  logic        s_axis_tuser_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [39:0] m_axis_tdata_o;

  logic [31:0] lvl_mem [NUM_LEVELS][SLOTS];
  int          lvl_head [NUM_LEVELS];
  int          lvl_count [NUM_LEVELS];
  logic [3:0]  model_levels;
  pq_reply_t   awaited_replies[$];
  int          err_count;
  int          hold_left;
  bit          idle_on;

  multi_level_priority_queue dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #2ms;
    $display("TB_ERROR");
    $finish;
  end

  function automatic pq_reply_t pq_apply(logic cmd, logic [31:0] value, logic [2:0] prio);
    pq_reply_t r;
    int        n;
    int        lv;
    n = (model_levels > NUM_LEVELS) ? NUM_LEVELS : model_levels;
    r.value = '0;
    r.status = ST_OK;
    if (cmd == CMD_INSERT) begin
      if (prio >= n) begin
        r.status = ST_BAD_PRIO;
      end else if (lvl_count[prio] >= SLOTS) begin
        r.status = ST_FULL;
      end else begin
        lvl_mem[prio][(lvl_head[prio] + lvl_count[prio]) % SLOTS] = value;
        lvl_count[prio]++;
      end
    end else begin
      r.status = ST_EMPTY;
      for (lv = n - 1; lv >= 0; lv--) begin
        if (lvl_count[lv] != 0) begin
          r.value = lvl_mem[lv][lvl_head[lv]];
          lvl_head[lv] = (lvl_head[lv] + 1) % SLOTS;
          lvl_count[lv]--;
          r.status = ST_OK;
          break;
        end
      end
    end
    r.empty = 1'b1;
    r.full = 1'b1;
    for (lv = 0; lv < n; lv++) begin
      if (lvl_count[lv] != 0) r.empty = 1'b0;
      if (lvl_count[lv] < SLOTS) r.full = 1'b0;
    end
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s expected %h actual %h", name, want, got);
      err_count++;
    end
  endfunction

  always @(posedge clk_i) begin : reply_check
    pq_reply_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (awaited_replies.size() == 0) begin
        $error("result with no request outstanding: %h", m_axis_tdata_o);
        err_count++;
      end else begin
        want = awaited_replies.pop_front();
        check_field("removed_value", want.value, m_axis_tdata_o[31:0]);
        check_field("status", 32'(want.status), 32'(m_axis_tdata_o[33:32]));
        check_field("queue_empty", 32'(want.empty), 32'(m_axis_tdata_o[34]));
        check_field("queue_full", 32'(want.full), 32'(m_axis_tdata_o[35]));
      end
    end
  end

  // The receiver counts down a requested hold-off itself, then idles at random.
  initial begin
    m_axis_tready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        m_axis_tready_i = 1'b0;
        hold_left--;
      end else begin
        m_axis_tready_i = !(idle_on && $urandom_range(99) < 21);
      end
    end
  end

  task automatic send_req(logic cmd, logic [31:0] value, logic [2:0] prio);
    while (idle_on && $urandom_range(99) < 21) begin
      s_axis_tvalid_i = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i = 1'b1;
    s_axis_tuser_i = cmd;
    s_axis_tdata_i = {5'b0, prio, value};
    do @(posedge clk_i); while (!s_axis_tready_o);
    awaited_replies.push_back(pq_apply(cmd, value, prio));
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    s_axis_tvalid_i = 1'b0;
    while (awaited_replies.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_levels(logic [3:0] levels);
    wait_drained();
    cfg_we_i = 1'b1;
    cfg_wdata_i = levels;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    model_levels = levels;
  endtask

  task automatic run_random(logic [3:0] levels, int count, int insert_pct);
    int          n;
    logic        cmd;
    logic [2:0]  prio;
    write_levels(levels);
    n = (levels > NUM_LEVELS) ? NUM_LEVELS : levels;
    for (int i = 0; i < count; i++) begin
      cmd = ($urandom_range(99) < insert_pct) ? CMD_INSERT : CMD_REMOVE;
      if (n > 0 && $urandom_range(99) < 85) prio = 3'($urandom_range(n - 1));
      else prio = 3'($urandom_range(7));
      send_req(cmd, $urandom, prio);
    end
  endtask

  task automatic test_service_order();
    send_req(CMD_REMOVE, 32'h1234_5678, 3'd5);
    send_req(CMD_INSERT, 32'h0000_0000, 3'd0);
    send_req(CMD_INSERT, 32'hFFFF_FFFF, 3'd7);
    send_req(CMD_INSERT, 32'hA5A5_5A5A, 3'd3);
    repeat (4) send_req(CMD_REMOVE, $urandom, 3'($urandom_range(7)));
  endtask

  task automatic test_no_levels();
    write_levels(4'd0);
    send_req(CMD_INSERT, 32'hDEAD_BEEF, 3'd0);
    send_req(CMD_REMOVE, 32'h0, 3'd0);
  endtask

  task automatic test_level_full();
    write_levels(4'd1);
    for (int i = 0; i < SLOTS + 1; i++) send_req(CMD_INSERT, 32'h100 + i, 3'd0);
  endtask

  task automatic test_backpressure();
    write_levels(4'd8);
    @(posedge clk_i);
    hold_left = 300;
    @(negedge clk_i);
    for (int i = 0; i < 40; i++) begin
      send_req(($urandom_range(99) < 60) ? CMD_INSERT : CMD_REMOVE, $urandom,
               3'($urandom_range(7)));
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i = '0;
    s_axis_tuser_i = CMD_INSERT;
    err_count = 0;
    hold_left = 0;
    idle_on = 1'b1;
    model_levels = 4'd8;
    for (int i = 0; i < NUM_LEVELS; i++) begin
      lvl_head[i] = 0;
      lvl_count[i] = 0;
    end
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_service_order();
    test_no_levels();
    test_level_full();
    run_random(4'd8, 160, 90);
    idle_on = 1'b0;
    run_random(4'd3, 80, 45);
    idle_on = 1'b1;
    run_random(4'd12, 130, 25);
    run_random(4'd1, 60, 55);
    run_random(4'd15, 60, 50);
    test_backpressure();
    wait_drained();

    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
